@@ hdl/periodic_task_timer_table_core_defines.svh @@
// Assertion helpers used by the RTL sequencer.
`ifndef PERIODIC_TASK_TIMER_TABLE_CORE_DEFINES_SVH
`define PERIODIC_TASK_TIMER_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PTT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ptt_pkg.sv @@
package ptt_pkg;

  localparam int unsigned IdW      = 8;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned MaxResults = 8;
  localparam int unsigned CntW     = 4;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TICK     = 2'd2,
    OP_DISPATCH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_e;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [TicksW-1:0] delay;
    logic [TicksW-1:0] period;
    logic              rdy;
  } slot_t;

  // one result item
  typedef struct packed {
    logic           status;
    logic [IdW-1:0] ready_id;
    logic           last;
  } res_t;

endpackage

@@ hdl/ptt_slot_mem.sv @@
module ptt_slot_mem #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              re_i,
  input  logic [(NUM_SLOTS>1 ? $clog2(NUM_SLOTS) : 1)-1:0] raddr_i,
  output ptt_pkg::slot_t                    rdata_o,
  input  logic                              we_i,
  input  logic [(NUM_SLOTS>1 ? $clog2(NUM_SLOTS) : 1)-1:0] waddr_i,
  input  ptt_pkg::slot_t                    wdata_i
);

  ptt_pkg::slot_t        mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  vld_q;
  ptt_pkg::slot_t        rdata_q;
  logic                  rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // per-entry valid: an entry never written reads as a cleared slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

@@ hdl/ptt_out_buf.sv @@
module ptt_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ptt_pkg::res_t res_i,
  output logic          free_o,
  output logic          valid_o,
  input  logic          ready_i,
  output ptt_pkg::res_t res_o
);

  logic          vld_q, vld_d;
  ptt_pkg::res_t res_q;

  assign free_o = !vld_q || ready_i;

  always_comb begin
    vld_d = vld_q;
    if (push_i) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

@@ hdl/ptt_seq.sv @@
`include "periodic_task_timer_table_core_defines.svh"

module ptt_seq #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  ptt_pkg::op_e                  op_i,
  input  logic [ptt_pkg::IdW-1:0]       id_i,
  input  logic [ptt_pkg::TicksW-1:0]    delay_i,
  input  logic [ptt_pkg::TicksW-1:0]    period_i,
  // slot memory
  output logic                          mem_re_o,
  output logic [(NUM_SLOTS>1 ? $clog2(NUM_SLOTS) : 1)-1:0] mem_raddr_o,
  input  ptt_pkg::slot_t                mem_rdata_i,
  output logic                          mem_we_o,
  output logic [(NUM_SLOTS>1 ? $clog2(NUM_SLOTS) : 1)-1:0] mem_waddr_o,
  output ptt_pkg::slot_t                mem_wdata_o,
  // result buffer
  input  logic                          out_free_i,
  output logic                          push_o,
  output ptt_pkg::res_t                 res_o
);

  localparam int unsigned IdxW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  ptt_pkg::state_e              state_q, state_d;
  ptt_pkg::op_e                 op_q;
  logic [ptt_pkg::IdW-1:0]      id_q;
  logic [ptt_pkg::TicksW-1:0]   dly_q, per_q;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic                         found_q, found_d;
  logic [ptt_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic                         pend_q, pend_d;
  logic [ptt_pkg::IdW-1:0]      pend_id_q, pend_id_d;
  logic                         accept, stall, is_last;
  ptt_pkg::slot_t               ent;

  assign accept  = (state_q == ptt_pkg::ST_IDLE) && req_valid_i;
  assign is_last = (idx_q == LastIdx);
  assign ent     = mem_rdata_i;
  assign req_ready_o = (state_q == ptt_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    found_d     = found_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    stall       = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = ent;
    push_o      = 1'b0;
    res_o       = '0;

    case (state_q)
      ptt_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ptt_pkg::ST_WALK;
          idx_d   = '0;
          found_d = 1'b0;
          cnt_d   = '0;
          pend_d  = 1'b0;
        end
      end
      ptt_pkg::ST_WALK: begin
        case (op_q)
          ptt_pkg::OP_ADD: begin
            if (!found_q && id_q != '0 && ent.id == '0) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = '{id: id_q, delay: dly_q, period: per_q, rdy: 1'b0};
              found_d     = 1'b1;
            end
          end
          ptt_pkg::OP_DELETE: begin
            if (!found_q && id_q != '0 && ent.id == id_q) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = '0;
              found_d     = 1'b1;
            end
          end
          ptt_pkg::OP_TICK: begin
            if (ent.id != '0) begin
              mem_we_o = 1'b1;
              if (ent.delay == '0) begin
                mem_wdata_o.rdy   = 1'b1;
                mem_wdata_o.delay = ent.period;
              end else begin
                mem_wdata_o.delay = ent.delay - 1'b1;
              end
            end
          end
          default: begin
            // dispatch: hold one found id back so the final one can carry last
            if (ent.rdy) begin
              if (pend_q && !out_free_i) begin
                stall = 1'b1;
              end else begin
                push_o          = pend_q;
                res_o.ready_id  = pend_id_q;
                mem_we_o        = 1'b1;
                mem_wdata_o.rdy = 1'b0;
                if (ent.period == '0) begin
                  mem_wdata_o.id    = '0;
                  mem_wdata_o.delay = '0;
                end
                pend_d    = 1'b1;
                pend_id_d = ent.id;
                cnt_d     = cnt_q + 1'b1;
              end
            end
          end
        endcase
        if (!stall) begin
          if (is_last || cnt_d == ptt_pkg::CntW'(ptt_pkg::MaxResults)) begin
            state_d = ptt_pkg::ST_FIN;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ptt_pkg::ST_FIN: begin
        if (out_free_i) begin
          push_o         = 1'b1;
          res_o.status   = (op_q == ptt_pkg::OP_ADD) && (id_q != '0) && !found_q;
          res_o.ready_id = pend_q ? pend_id_q : '0;
          res_o.last     = 1'b1;
          pend_d         = 1'b0;
          state_d        = ptt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptt_pkg::ST_IDLE;
      end
    endcase
  end

  // read ahead one slot; on a stall the current slot is read again
  assign mem_re_o    = accept || (state_q == ptt_pkg::ST_WALK && (stall || !is_last));
  assign mem_raddr_o = accept ? '0 : (stall ? idx_q : idx_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptt_pkg::ST_IDLE;
      idx_q   <= '0;
      found_q <= 1'b0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    if (accept) begin
      op_q  <= op_i;
      id_q  <= id_i;
      dly_q <= delay_i;
      per_q <= period_i;
    end
  end

  `PTT_ASSERT_SAME(a_push_room, push_o, out_free_i, "result pushed into a full buffer")
  `PTT_ASSERT_SAME(a_cnt_cap, 1'b1, cnt_q <= ptt_pkg::CntW'(ptt_pkg::MaxResults), "too many results")
  `PTT_ASSERT_SAME(a_we_walk, mem_we_o, state_q == ptt_pkg::ST_WALK && !stall, "table write outside walk")
  `PTT_ASSERT_NEXT(a_fin_idle, state_q == ptt_pkg::ST_FIN && out_free_i, state_q == ptt_pkg::ST_IDLE && !pend_q, "final result did not close the request")

endmodule

@@ hdl/periodic_task_timer_table_core.sv @@
// Periodic task timer table: NUM_SLOTS task slots (id, delay, period, ready)
// kept in one synchronous slot memory and updated by a read-modify-write walk,
// one slot per clock while no stall holds it. Requests on the slave stream
// carry the operation in tuser (add, delete, tick, dispatch). Add, delete and
// tick each return one result; dispatch returns the ids of ready slots in
// ascending order (at most eight per request, last one flagged by tlast), or
// a single id 0 when none is ready. A request is accepted, walks every slot
// and then sends its final result; a dispatch stops its walk after the
// eighth ready slot, and its walk stalls while the result register is full
// and another result is due. One request is in progress at a time; a new
// one is taken while the last result still waits in the output register.
// The table is empty after reset at once, with no clearing pass.
module periodic_task_timer_table_core #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [7:0] task_id, [23:8] delay_ticks, [39:24] period_ticks
  input  logic [1:0]  s_axis_tuser,  // [1:0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] ready_id
  output logic        m_axis_tuser,  // [0] status (table full on add)
  output logic        m_axis_tlast   // last result of a request
);

  localparam int unsigned IdxW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;

  logic            mem_re, mem_we;
  logic [IdxW-1:0] mem_raddr, mem_waddr;
  ptt_pkg::slot_t  mem_rdata, mem_wdata;
  logic            out_free, push;
  ptt_pkg::res_t   res_in, res_out;

  // slot table storage
  ptt_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // request sequencer: walks the slots and produces results
  ptt_seq #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .op_i        (ptt_pkg::op_e'(s_axis_tuser)),
    .id_i        (s_axis_tdata[7:0]),
    .delay_i     (s_axis_tdata[23:8]),
    .period_i    (s_axis_tdata[39:24]),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .out_free_i  (out_free),
    .push_o      (push),
    .res_o       (res_in)
  );

  // result register between the walk and the result stream
  ptt_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res_in),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tdata = res_out.ready_id;
  assign m_axis_tuser = res_out.status;
  assign m_axis_tlast = res_out.last;

endmodule
